// ===== sv/scca_pkg.sv =====
// Package for the segment/circle chord and arc accumulator.
// Holds widths, the FSM state type, register codes, serial MAC steps and the CORDIC table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scca_pkg;

  localparam int COORD_W      = 32;
  localparam int RADIUS_W     = 31;
  localparam int OUT_W        = 48;
  localparam int ACC_BITS_DEF = 48;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;
  localparam int GUARD_BITS   = 14;
  localparam int ANGLE_BITS   = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_RAD_W   = 94;

  typedef enum logic [1:0] {
    REG_SX,
    REG_SY,
    REG_EX,
    REG_EY
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_MAG,
    ST_MUL,
    ST_SGN,
    ST_SUM,
    ST_ABS,
    ST_SQL,
    ST_DIV,
    ST_DCHK,
    ST_MRD,
    ST_HSUB,
    ST_HST,
    ST_SQH,
    ST_CRD,
    ST_ARM,
    ST_ARC,
    ST_ACC,
    ST_ACD,
    ST_FIN
  } state_t;

  // One step of a right-shifting shift-add multiplier, 33-bit operands.
  function automatic logic [65:0] mac33(input logic [65:0] acc, input logic [32:0] m,
                                        input logic b);
    logic [33:0] s;
    s = {1'b0, acc[65:33]} + (b ? {1'b0, m} : 34'd0);
    return {s, acc[32:1]};
  endfunction

  // Same, 31-bit operands.
  function automatic logic [61:0] mac31(input logic [61:0] acc, input logic [30:0] m,
                                        input logic b);
    logic [31:0] s;
    s = {1'b0, acc[61:31]} + (b ? {1'b0, m} : 32'd0);
    return {s, acc[30:1]};
  endfunction

  // atan(2^-i) in units of 2^-30 rad, truncated except for the last three entries, which are rounded.
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/scca_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle (floor result).
// Depends on scca_pkg for the default radicand width.
`timescale 1ns / 1ps
`default_nettype none
module scca_isqrt #(
  parameter int RAD_W = scca_pkg::SQRT_RAD_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [RAD_W-1:0]   radicand,
  output logic                    done,
  output logic [RAD_W/2-1:0]      root
);
  import scca_pkg::*;

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W+1:0]  rem2;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;

  always_comb begin
    rem2    = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial   = (REM_W + 2)'({root_r, 2'b01});
    ge      = (rem2 >= trial);
    rem_nxt = ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== sv/segment_circle_chord_arc_sum_core.sv =====
// Top level: chord total of circles crossed by a configured segment, and its length plus the arc detours.
// Depends on scca_pkg and scca_isqrt.
//
//  port group | dir | handshake          | payload
//  -----------+-----+--------------------+-------------------------------------------
//  in_*       | in  | in_valid/in_stall   | center_x, center_y, radius, has_circle, last
//  out_*      | out | out_valid/out_stall | seen_through, flight_length
//  APB        | in  | psel/penable/pready | paddr, pwdata, prdata (segment ends)
//
// One item at a time. Every item runs the 33-step serial multiplier and the 47-step
// square-root unit. A circle whose foot falls on the segment adds the 80-step divider; if
// it lies closer than its radius, a 31-step multiply, a second root pass, 30 CORDIC steps
// and a 31-step multiply follow. A last item also loads the output register in ST_FIN.
// Reset clears the totals and the segment registers.
// A result waits in the output register; a last item that finds it still full holds
// until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module segment_circle_chord_arc_sum_core #(
  parameter int ACC_BITS = scca_pkg::ACC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [scca_pkg::COORD_W-1:0] in_center_x,
  input  wire logic signed [scca_pkg::COORD_W-1:0] in_center_y,
  input  wire logic [scca_pkg::RADIUS_W-1:0]     in_radius,
  input  wire logic                              in_has_circle,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [scca_pkg::OUT_W-1:0]             out_seen_through,
  output logic [scca_pkg::OUT_W-1:0]             out_flight_length,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [scca_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [scca_pkg::DATA_W-1:0]       pwdata,
  output logic [scca_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);
  import scca_pkg::*;

  localparam int SUM_W = ((ACC_BITS > 34) ? ACC_BITS : 34) + 1;

  function automatic logic [ACC_BITS-1:0] sat_acc(input logic [ACC_BITS-1:0] a,
                                                  input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + b;
    return (s[SUM_W-1:ACC_BITS] != '0) ? '1 : s[ACC_BITS-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [31:0] sx_r, sy_r, ex_r, ey_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  logic [31:0] cx_r, cy_r;
  logic [30:0] rad_r;
  logic        has_r, last_r;
  logic [32:0] ax_r, ay_r, bx_r, by_r;
  logic [32:0] max_r, may_r, mbx_r, mby_r;
  logic [32:0] mlx_r, mly_r;
  logic        s3_r, s4_r, s5_r, s6_r;
  logic [65:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic [66:0] t3_r, t4_r, t5_r, t6_r;
  logic [65:0] yy_r;
  logic [66:0] xy_r, cs_r;
  logic [65:0] cr_r;
  logic        ok_r;
  logic [46:0] lq_r;
  logic [79:0] num_r;
  logic [46:0] drem_r;
  logic [63:0] q_r;
  logic        ovf_r;
  logic [30:0] d_r, h_r;
  logic [30:0] mr_r, md_r, mz_r;
  logic [61:0] prr_r, pdd_r, par_r, hh_r;
  logic signed [63:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [32:0] dif_r;
  logic [6:0]  cnt_r;
  logic [ACC_BITS-1:0] chord_tot_r, detour_tot_r;
  logic        out_valid_r;
  logic [OUT_W-1:0] out_st_r, out_fl_r;

  logic        sq_start, sq_done;
  logic [SQRT_RAD_W-1:0] sq_rad;
  logic [SQRT_RAD_W/2-1:0] sq_root;

  logic [47:0] div_rem2;
  logic        div_ge;
  logic [4:0]  crd_i;
  logic signed [63:0] xs, ys;
  logic        y_pos;
  logic signed [31:0] atan_s;
  logic [32:0] arc, chord_ext;
  logic        out_free;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      ex_r <= '0;
      ey_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SX: sx_r <= pwdata;
        REG_SY: sy_r <= pwdata;
        REG_EX: ex_r <= pwdata;
        REG_EY: ey_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SX:  prdata = sx_r;
      REG_SY:  prdata = sy_r;
      REG_EX:  prdata = ex_r;
      REG_EY:  prdata = ey_r;
      default: prdata = '0;
    endcase
  end

  // ---------------- square root unit ----------------
  assign sq_rad = (state_r == ST_SUM) ? {yy_r, 28'b0} : {32'b0, hh_r};

  scca_isqrt #(
    .RAD_W(SQRT_RAD_W)
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .radicand(sq_rad),
    .done    (sq_done),
    .root    (sq_root)
  );

  // ---------------- FSM ----------------
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_MUL;
      ST_MUL:  if (cnt_r == 7'd0) state_nxt = ST_SGN;
      ST_SGN:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_SQL;
      ST_SQL: begin
        if (sq_done) begin
          if (ok_r)        state_nxt = ST_DIV;
          else if (last_r) state_nxt = ST_FIN;
          else             state_nxt = ST_IDLE;
        end
      end
      ST_DIV:  if (cnt_r == 7'd0) state_nxt = ST_DCHK;
      ST_DCHK: begin
        if (ovf_r || (q_r >= {33'b0, rad_r})) state_nxt = last_r ? ST_FIN : ST_IDLE;
        else                                  state_nxt = ST_MRD;
      end
      ST_MRD:  if (cnt_r == 7'd0) state_nxt = ST_HSUB;
      ST_HSUB: state_nxt = ST_HST;
      ST_HST:  state_nxt = ST_SQH;
      ST_SQH:  if (sq_done) state_nxt = ST_CRD;
      ST_CRD:  if (cnt_r == 7'(CORDIC_STEPS - 1)) state_nxt = ST_ARM;
      ST_ARM:  state_nxt = ST_ARC;
      ST_ARC:  if (cnt_r == 7'd0) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_ACD;
      ST_ACD:  state_nxt = last_r ? ST_FIN : ST_IDLE;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    sq_start = 1'b0;
    unique case (state_r)
      ST_IDLE:        in_stall = 1'b0;
      ST_SUM, ST_HST: sq_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- datapath ----------------
  assign div_rem2  = {drem_r, num_r[79]};
  assign div_ge    = (div_rem2 >= {1'b0, lq_r});
  assign crd_i     = cnt_r[4:0];
  assign xs        = x_r >>> crd_i;
  assign ys        = y_r >>> crd_i;
  assign y_pos     = !y_r[63] && (y_r != 64'sd0);
  assign atan_s    = $signed({2'b00, atan_lut(crd_i)});
  assign arc       = par_r[61:29];
  assign chord_ext = {1'b0, h_r, 1'b0};

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cx_r   <= in_center_x;
        cy_r   <= in_center_y;
        rad_r  <= in_radius;
        has_r  <= in_has_circle;
        last_r <= in_last;
      end
      ST_PREP: begin
        ax_r <= {cx_r[31], cx_r} - {sx_r[31], sx_r};
        ay_r <= {cy_r[31], cy_r} - {sy_r[31], sy_r};
        bx_r <= {ex_r[31], ex_r} - {sx_r[31], sx_r};
        by_r <= {ey_r[31], ey_r} - {sy_r[31], sy_r};
      end
      ST_MAG: begin
        max_r <= ax_r[32] ? -ax_r : ax_r;
        may_r <= ay_r[32] ? -ay_r : ay_r;
        mbx_r <= bx_r[32] ? -bx_r : bx_r;
        mby_r <= by_r[32] ? -by_r : by_r;
        mlx_r <= bx_r[32] ? -bx_r : bx_r;
        mly_r <= by_r[32] ? -by_r : by_r;
        s3_r  <= ax_r[32] ^ bx_r[32];
        s4_r  <= ay_r[32] ^ by_r[32];
        s5_r  <= ax_r[32] ^ by_r[32];
        s6_r  <= ay_r[32] ^ bx_r[32];
        p1_r  <= '0;
        p2_r  <= '0;
        p3_r  <= '0;
        p4_r  <= '0;
        p5_r  <= '0;
        p6_r  <= '0;
        cnt_r <= 7'd32;
      end
      ST_MUL: begin
        p1_r  <= mac33(p1_r, mbx_r, mlx_r[0]);
        p3_r  <= mac33(p3_r, max_r, mlx_r[0]);
        p6_r  <= mac33(p6_r, may_r, mlx_r[0]);
        p2_r  <= mac33(p2_r, mby_r, mly_r[0]);
        p4_r  <= mac33(p4_r, may_r, mly_r[0]);
        p5_r  <= mac33(p5_r, max_r, mly_r[0]);
        mlx_r <= {1'b0, mlx_r[32:1]};
        mly_r <= {1'b0, mly_r[32:1]};
        cnt_r <= cnt_r - 7'd1;
      end
      ST_SGN: begin
        t3_r <= s3_r ? -{1'b0, p3_r} : {1'b0, p3_r};
        t4_r <= s4_r ? -{1'b0, p4_r} : {1'b0, p4_r};
        t5_r <= s5_r ? -{1'b0, p5_r} : {1'b0, p5_r};
        t6_r <= s6_r ? -{1'b0, p6_r} : {1'b0, p6_r};
        yy_r <= p1_r + p2_r;
      end
      ST_SUM: begin
        xy_r <= t3_r + t4_r;
        cs_r <= t5_r - t6_r;
      end
      ST_ABS: begin
        cr_r <= cs_r[66] ? 66'(-cs_r) : cs_r[65:0];
        ok_r <= has_r && (yy_r != '0) && !xy_r[66] && (xy_r[65:0] <= yy_r);
      end
      ST_SQL: begin
        if (sq_done) begin
          lq_r   <= sq_root;
          num_r  <= {cr_r, 14'b0};
          drem_r <= '0;
          q_r    <= '0;
          ovf_r  <= 1'b0;
          cnt_r  <= 7'd79;
        end
      end
      ST_DIV: begin
        drem_r <= div_ge ? 47'(div_rem2 - {1'b0, lq_r}) : div_rem2[46:0];
        q_r    <= {q_r[62:0], div_ge};
        ovf_r  <= ovf_r || (div_ge && (cnt_r >= 7'd64));
        num_r  <= {num_r[78:0], 1'b0};
        cnt_r  <= cnt_r - 7'd1;
      end
      ST_DCHK: begin
        d_r   <= q_r[30:0];
        mr_r  <= rad_r;
        md_r  <= q_r[30:0];
        prr_r <= '0;
        pdd_r <= '0;
        cnt_r <= 7'd30;
      end
      ST_MRD: begin
        prr_r <= mac31(prr_r, rad_r, mr_r[0]);
        pdd_r <= mac31(pdd_r, d_r, md_r[0]);
        mr_r  <= {1'b0, mr_r[30:1]};
        md_r  <= {1'b0, md_r[30:1]};
        cnt_r <= cnt_r - 7'd1;
      end
      ST_HSUB: hh_r <= prr_r - pdd_r;
      ST_SQH: begin
        if (sq_done) begin
          h_r   <= sq_root[30:0];
          x_r   <= $signed({3'b000, d_r, 30'b0});
          y_r   <= $signed({3'b000, sq_root[30:0], 30'b0});
          z_r   <= '0;
          cnt_r <= '0;
        end
      end
      ST_CRD: begin
        if (y_pos) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_s;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_s;
        end
        cnt_r <= cnt_r + 7'd1;
      end
      ST_ARM: begin
        mz_r  <= z_r[31] ? 31'd0 : z_r[30:0];
        par_r <= '0;
        cnt_r <= 7'd30;
      end
      ST_ARC: begin
        par_r <= mac31(par_r, rad_r, mz_r[0]);
        mz_r  <= {1'b0, mz_r[30:1]};
        cnt_r <= cnt_r - 7'd1;
      end
      ST_ACC:  dif_r <= (arc > chord_ext) ? (arc - chord_ext) : 33'd0;
      default: ;
    endcase
  end

  // totals and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chord_tot_r  <= '0;
      detour_tot_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if ((state_r == ST_FIN) && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)  out_valid_r <= 1'b0;
      case (state_r)
        ST_ACC: chord_tot_r  <= sat_acc(chord_tot_r, SUM_W'(chord_ext));
        ST_ACD: detour_tot_r <= sat_acc(detour_tot_r, SUM_W'(dif_r));
        ST_FIN: begin
          if (out_free) begin
            chord_tot_r  <= '0;
            detour_tot_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      out_st_r <= OUT_W'(chord_tot_r);
      out_fl_r <= OUT_W'(sat_acc(detour_tot_r, SUM_W'(lq_r[46:GUARD_BITS])));
    end
  end

  assign out_valid         = out_valid_r;
  assign out_seen_through  = out_st_r;
  assign out_flight_length = out_fl_r;

endmodule
`default_nettype wire

// ===== sv/scca_checker.sv =====
// Port-level checks for segment_circle_chord_arc_sum_core, bound to the top level.
// Depends on scca_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none
module scca_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [scca_pkg::OUT_W-1:0]    out_seen_through,
  input wire logic [scca_pkg::OUT_W-1:0]    out_flight_length,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pready
);
  import scca_pkg::*;

  // one item at a time: an accepted item closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a result appears only out of a busy phase
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without an item in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_seen_through)
      && $stable(out_flight_length))
    else $error("stalled result changed");

  a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable |-> pready)
    else $error("APB access not ready");

endmodule

bind segment_circle_chord_arc_sum_core scca_checker u_scca_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_seen_through (out_seen_through),
  .out_flight_length(out_flight_length),
  .psel             (psel),
  .penable          (penable),
  .pready           (pready)
);
`default_nettype wire

// ===== verif/scca_checker.sv =====
// Checker for the segment/circle chord and arc accumulator: watches the item channels and
// the register port, predicts the totals and compares each result item.
// Depends on scca_pkg.
`timescale 1ns / 1ps
module scca_tb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [scca_pkg::COORD_W-1:0]   in_center_x,
  input  logic [scca_pkg::COORD_W-1:0]   in_center_y,
  input  logic [scca_pkg::RADIUS_W-1:0]  in_radius,
  input  logic                           in_has_circle,
  input  logic                           in_last,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [scca_pkg::OUT_W-1:0]     out_seen_through,
  input  logic [scca_pkg::OUT_W-1:0]     out_flight_length,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [scca_pkg::ADDR_W-1:0]    paddr,
  input  logic [scca_pkg::DATA_W-1:0]    pwdata,
  output int unsigned                    fail_count,
  output int unsigned                    totals_owed,
  output int unsigned                    totals_checked
);
  import scca_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] seen;
    logic [OUT_W-1:0] flight;
  } totals_t;

  localparam longint ATAN_Q30 [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 8, 4, 2
  };

  totals_t          owed_q[$];
  logic [31:0]      seg_q[4];
  logic [OUT_W-1:0] chord_sum;
  logic [OUT_W-1:0] detour_sum;

  function automatic logic signed [127:0] wide(input longint v);
    return v;
  endfunction

  function automatic logic [63:0] root_of(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] sat_sum(input logic [OUT_W-1:0] a,
                                               input logic [OUT_W-1:0] b);
    logic [OUT_W:0] s;
    s = a + b;
    return s[OUT_W] ? '1 : s[OUT_W-1:0];
  endfunction

  function automatic longint seg_dx();
    return longint'($signed(seg_q[REG_EX])) - longint'($signed(seg_q[REG_SX]));
  endfunction

  function automatic longint seg_dy();
    return longint'($signed(seg_q[REG_EY])) - longint'($signed(seg_q[REG_SY]));
  endfunction

  function automatic logic signed [127:0] seg_len_sq();
    return wide(seg_dx()) * wide(seg_dx()) + wide(seg_dy()) * wide(seg_dy());
  endfunction

  task automatic add_circle(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [30:0] r);
    longint ax, ay, bx, by, x, y, nx, z;
    logic signed [127:0] yy, xy, cr;
    logic [127:0] dq;
    logic [63:0] lq, d, h, rr, chord, arc;
    bx = seg_dx();
    by = seg_dy();
    ax = longint'($signed(cx)) - longint'($signed(seg_q[REG_SX]));
    ay = longint'($signed(cy)) - longint'($signed(seg_q[REG_SY]));
    yy = seg_len_sq();
    if (yy == 0) return;
    xy = wide(ax) * wide(bx) + wide(ay) * wide(by);
    if (xy < 0 || xy > yy) return;
    cr = wide(ax) * wide(by) - wide(ay) * wide(bx);
    if (cr < 0) cr = -cr;
    lq = root_of(yy << (2 * GUARD_BITS));
    dq = (128'(cr) << GUARD_BITS) / {64'd0, lq};
    d = (dq[127:64] != 0) ? '1 : dq[63:0];
    rr = {33'd0, r};
    if (d >= rr) return;
    h = root_of({64'd0, rr * rr - d * d});
    x = longint'(d << ANGLE_BITS);
    y = longint'(h << ANGLE_BITS);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_Q30[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_Q30[i];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    chord = h << 1;
    arc = (rr * 64'(z)) >> (ANGLE_BITS - 1);
    chord_sum = sat_sum(chord_sum, chord[OUT_W-1:0]);
    if (arc > chord) detour_sum = sat_sum(detour_sum, OUT_W'(arc - chord));
  endtask

  always @(posedge clk) begin
    totals_t exp_t;
    logic [63:0] len;
    if (!rst_n) begin
      owed_q.delete();
      for (int i = 0; i < 4; i++) seg_q[i] = '0;
      chord_sum = '0;
      detour_sum = '0;
      fail_count <= 0;
      totals_checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
        seg_q[paddr[3:2]] = pwdata;
      if (in_valid && !in_stall) begin
        if (in_has_circle) add_circle(in_center_x, in_center_y, in_radius);
        if (in_last) begin
          len = root_of(seg_len_sq());
          exp_t.seen = chord_sum;
          exp_t.flight = sat_sum(len[OUT_W-1:0], detour_sum);
          owed_q.push_back(exp_t);
          chord_sum = '0;
          detour_sum = '0;
        end
      end
      if (out_valid && !out_stall) begin
        totals_checked <= totals_checked + 1;
        if (owed_q.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result item: seen %0d flight %0d", $realtime,
                     out_seen_through, out_flight_length);
          fail_count <= fail_count + 1;
        end else begin
          exp_t = owed_q.pop_front();
          if (exp_t.seen !== out_seen_through || exp_t.flight !== out_flight_length) begin
            if (fail_count < 10)
              $display("[%0t] mismatch: seen exp %0d got %0d, flight exp %0d got %0d",
                       $realtime, exp_t.seen, out_seen_through, exp_t.flight,
                       out_flight_length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    totals_owed <= owed_q.size();
  end
endmodule

// ===== verif/tb_segment_circle_chord_arc_sum_core.sv =====
// Testbench top for segment_circle_chord_arc_sum_core: clock, reset, segment register writes,
// circle item stimulus, result-side stalls and the verdict. Depends on scca_pkg, scca_checker.
`timescale 1ns / 1ps
module tb_segment_circle_chord_arc_sum_core;
  import scca_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 400;
  localparam int HOLD_LEN   = 1500;

  logic clk, rst_n;
  logic in_valid, in_stall, in_has_circle, in_last;
  logic [COORD_W-1:0] in_center_x, in_center_y;
  logic [RADIUS_W-1:0] in_radius;
  logic out_valid, out_stall;
  logic [OUT_W-1:0] out_seen_through, out_flight_length;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int unsigned fail_count, totals_owed, totals_checked;
  int unsigned idle_cycles, items_sent, sets_sent, segs_used;
  bit hold_req, rx_eager;

  segment_circle_chord_arc_sum_core dut (.*);

  scca_tb_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_center_x, .in_center_y, .in_radius,
    .in_has_circle, .in_last, .out_valid, .out_stall, .out_seen_through,
    .out_flight_length, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .totals_owed, .totals_checked
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side
  initial begin
    int n;
    out_stall = 1;
    rx_eager = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 0;
      end
      if ($urandom_range(0, 15) == 0) rx_eager = !rx_eager;
      n = rx_eager ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sh7fffffff) return 32'h7fffffff;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [31:0] cx, input logic [31:0] cy, input logic [30:0] r,
                           input bit hc, input bit lst, input int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius <= r;
    in_has_circle <= hc;
    in_last <= lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (lst) sets_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (totals_owed != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_segment(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] ex, input logic [31:0] ey);
    drain();
    reg_write(REG_SX, sx);
    reg_write(REG_SY, sy);
    reg_write(REG_EX, ex);
    reg_write(REG_EY, ey);
    segs_used++;
  endtask

  // circles mostly placed near the segment so that many cross it
  task automatic random_sets(input logic [31:0] s[4], input int n_items, input bit no_gaps);
    longint sx, sy, bx, by, span, t;
    int left, len, gap;
    bit quiet;
    logic [31:0] cx, cy;
    logic [30:0] r;
    bit hc;
    sx = $signed(s[0]);
    sy = $signed(s[1]);
    bx = longint'($signed(s[2])) - sx;
    by = longint'($signed(s[3])) - sy;
    span = ((bx < 0 ? -bx : bx) + (by < 0 ? -by : by)) / 8 + 1;
    if (span > 64'd1 << 30) span = 64'd1 << 30;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 6);
      if (len > left) len = left;
      quiet = no_gaps || $urandom_range(0, 3) == 0;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          cx = $urandom;
          cy = $urandom;
          r = 31'($urandom);
          hc = 1'($urandom_range(0, 1));
        end else begin
          t = longint'($urandom_range(0, 1152)) - 64;
          cx = clip32(sx + bx * t / 1024 + longint'($urandom_range(0, 2 * span)) - span);
          cy = clip32(sy + by * t / 1024 + longint'($urandom_range(0, 2 * span)) - span);
          r = 31'($urandom_range(0, 2 * span > 64'h7fffffff ? 32'h7fffffff : 2 * span));
          hc = $urandom_range(0, 7) != 0;
        end
        gap = quiet ? 0 : $urandom_range(0, 12);
        send_item(cx, cy, r, hc, k == len - 1, gap);
      end
      left -= len;
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  initial begin
    logic [31:0] segs [8][4];
    rst_n = 0;
    in_valid = 0;
    in_center_x = '0;
    in_center_y = '0;
    in_radius = '0;
    in_has_circle = 0;
    in_last = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    hold_req = 0;
    items_sent = 0;
    sets_sent = 0;
    segs_used = 0;
    idle_cycles = 0;
    segs = '{
      '{32'd0, 32'd0, 32'd100 << 16, 32'd0},
      '{-(32'd5 << 16), 32'd3 << 16, 32'd7 << 16, -(32'd9 << 16)},
      '{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff},
      '{32'h7fffffff, 32'h0, 32'h80000000, 32'h0},
      '{32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd0, 32'd0, 32'd1, 32'd1},
      '{$urandom, $urandom, $urandom, $urandom},
      '{$urandom_range(0, 32'hfffff), $urandom_range(0, 32'hfffff),
        $urandom_range(0, 32'hfffff), $urandom_range(0, 32'hfffff)}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // zero-length segment straight out of reset
    send_item(32'd0, 32'd0, 31'd1 << 16, 1, 0, 0);
    send_item(32'd5 << 16, 32'd0, 31'h7fffffff, 1, 1, 0);

    set_segment(32'd0, 32'd0, 32'd100 << 16, 32'd0);
    send_item($urandom, $urandom, 31'($urandom), 0, 1, 0);            // empty set
    send_item(32'd50 << 16, 32'd30 << 16, 31'd50 << 16, 1, 1, 3);     // plain chord
    send_item(32'd50 << 16, 32'd30 << 16, 31'd30 << 16, 1, 1, 0);     // tangent
    send_item(-(32'd10 << 16), 32'd5 << 16, 31'd50 << 16, 1, 1, 0);   // foot before start
    send_item(32'd101 << 16, -(32'd5 << 16), 31'd50 << 16, 1, 1, 0);  // foot past end
    send_item(32'd0, 32'd5 << 16, 31'd10 << 16, 1, 0, 0);             // foot on ends
    send_item(32'd100 << 16, 32'd5 << 16, 31'd10 << 16, 1, 1, 2);
    send_item(32'd50 << 16, 32'd0, 31'd10 << 16, 1, 1, 0);            // center on line
    send_item(32'd50 << 16, 32'd0, 31'd0, 1, 1, 0);                   // zero radius
    send_item(32'd50 << 16, -32'd1, 31'h7fffffff, 1, 1, 0);           // max radius
    send_item(32'h80000000, 32'h7fffffff, 31'h7fffffff, 1, 1, 0);
    send_item(32'h7fffffff, 32'h80000000, 31'h7fffffff, 1, 1, 0);
    send_item($urandom, $urandom, 31'($urandom), 0, 0, 0);            // several in one set
    send_item(32'd20 << 16, 32'd1, 31'd3 << 16, 1, 0, 0);
    send_item(32'd60 << 16, -(32'd2 << 16), 31'd7 << 16, 1, 0, 5);
    send_item(32'd99 << 16, 32'd1 << 15, 31'd1 << 16, 1, 1, 0);

    for (int p = 0; p < 8; p++) begin
      set_segment(segs[p][0], segs[p][1], segs[p][2], segs[p][3]);
      if (p == 1) hold_req = 1;
      random_sets(segs[p], 240, p == 1);
    end
    drain();

    $display("covered %0d items in %0d sets over %0d segment settings, %0d results checked",
             items_sent, sets_sent, segs_used, totals_checked);
    if (fail_count == 0 && totals_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
